// ----- hw/rtl/rgn_pkg.sv -----
// Shared constants and types of the regularized gradient normalizer.
package rgn_pkg;

  localparam int LEVEL_W = 32;
  localparam int DIST_W  = 32;
  localparam int DIR_W   = 19;
  // Magnitude, squares, sum, regularization (three stages), regularized sum.
  localparam int FRONT_STAGES = 7;

  typedef struct packed {
    logic [2:0] grad;
    logic       level;
  } sign_t;

endpackage

// ----- hw/rtl/rgn_in_if.sv -----
// Input and output item channels of the regularized gradient normalizer.
interface rgn_in_if #(
  parameter int GRAD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic [rgn_pkg::LEVEL_W-1:0]   level_value;
  logic [GRAD_WIDTH-1:0]         grad_x;
  logic [GRAD_WIDTH-1:0]         grad_y;
  logic [GRAD_WIDTH-1:0]         grad_z;

  modport source (output valid, level_value, grad_x, grad_y, grad_z, input ready);
  modport sink   (input valid, level_value, grad_x, grad_y, grad_z, output ready);
endinterface

interface rgn_out_if;
  logic                        valid;
  logic                        ready;
  logic [rgn_pkg::DIST_W-1:0]  distance;
  logic [rgn_pkg::DIR_W-1:0]   dir_x;
  logic [rgn_pkg::DIR_W-1:0]   dir_y;
  logic [rgn_pkg::DIR_W-1:0]   dir_z;

  modport source (output valid, distance, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, distance, dir_x, dir_y, dir_z, output ready);
endinterface

// ----- hw/rtl/rgn_sqrt.sv -----
// Pipelined restoring integer square root, one root bit per stage.
module rgn_sqrt #(
  parameter int QS = 50
) (
  input  logic            clk,
  input  logic [QS/2-1:0] en,
  input  logic [QS-1:0]   x,
  output logic [QS/2-1:0] root
);

  localparam int RW = QS / 2;

  logic [RW+1:0] rem [RW];
  logic [RW-1:0] rt  [RW];
  logic [QS-1:0] xs  [RW-1];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RW+1:0] rem_in;
    logic [RW-1:0] rt_in;
    logic [QS-1:0] x_in;
    logic [RW+3:0] cur;
    logic [RW+3:0] sub;
    logic [RW+3:0] dif;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign rt_in  = '0;
      assign x_in   = x;
    end else begin : g_rest
      assign rem_in = rem[j-1];
      assign rt_in  = rt[j-1];
      assign x_in   = xs[j-1];
    end

    assign cur = {rem_in, x_in[QS-1 -: 2]};
    assign sub = {2'b00, rt_in, 2'b01};
    assign dif = cur - sub;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        if (cur >= sub) begin
          rem[j] <= dif[RW+1:0];
          rt[j]  <= {rt_in[RW-2:0], 1'b1};
        end else begin
          rem[j] <= cur[RW+1:0];
          rt[j]  <= {rt_in[RW-2:0], 1'b0};
        end
      end
    end

    if (j < RW - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en[j]) begin
          xs[j] <= {x_in[QS-3:0], 2'b00};
        end
      end
    end
  end

  assign root = rt[RW-1];

endmodule

// ----- hw/rtl/rgn_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rgn_div #(
  parameter int DV = 48,
  parameter int QB = 32,
  parameter int SW = 25
) (
  input  logic          clk,
  input  logic [QB-1:0] en,
  input  logic [DV-1:0] num,
  input  logic [SW-1:0] den,
  output logic [QB-1:0] quot,
  output logic          ovf
);

  logic [SW-1:0] rem [QB-1];
  logic [QB-1:0] low [QB-1];
  logic [SW-1:0] dq  [QB-1];
  logic [QB-1:0] qt  [QB];
  logic          ov  [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [SW-1:0] rem_in;
    logic [QB-1:0] low_in;
    logic [SW-1:0] den_in;
    logic [QB-1:0] q_in;
    logic          ov_in;
    logic [SW:0]   cur;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = SW'(num[DV-1:QB]);
      assign low_in = num[QB-1:0];
      assign den_in = den;
      assign q_in   = '0;
      // quotient needs more than QB bits when the high part reaches the divisor
      assign ov_in  = SW'(num[DV-1:QB]) >= den;
    end else begin : g_rest
      assign rem_in = rem[j-1];
      assign low_in = low[j-1];
      assign den_in = dq[j-1];
      assign q_in   = qt[j-1];
      assign ov_in  = ov[j-1];
    end

    assign cur = {rem_in, low_in[QB-1]};
    assign ge  = cur >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en[j]) begin
        qt[j] <= {q_in[QB-2:0], ge};
        ov[j] <= ov_in;
      end
    end

    if (j < QB - 1) begin : g_carry
      logic [SW:0] dif;
      assign dif = cur - {1'b0, den_in};
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem[j] <= ge ? dif[SW-1:0] : cur[SW-1:0];
          low[j] <= {low_in[QB-2:0], 1'b0};
          dq[j]  <= den_in;
        end
      end
    end
  end

  assign quot = qt[QB-1];
  assign ovf  = ov[QB-1];

endmodule

// ----- hw/rtl/regularized_gradient_normalizer_core.sv -----
// Top level of the regularized gradient normalizer pipeline.
//
// Usage: one item per mesh cell enters on in_ch (level_value, grad_x/y/z) and
// one result leaves on out_ch (distance, dir_x/y/z). Both channels move an
// item on a clock edge where valid and ready are both high.
// Pipeline: the front stages, the square root and the dividers, then the
// output stage. RW = ceil(max(2*GRAD_WIDTH+2, 2*FRAC_BITS+1) / 2) is the
// root width. The square root takes one stage per root bit and each of the
// four dividers one stage per quotient bit.
// Throughput: one item per cycle unless out_ch stalls. Every stage holds its
// own valid bit and loads whenever it is empty or its successor loads, so
// bubbles close up and new items keep entering while a finished result waits
// in the output stage. A stalled receiver holds the output stage; once the
// pipeline is full, in_ch.ready drops. Nothing is lost or repeated.
// Reset (rst, synchronous) empties all stages; no clearing pass is needed.
// The in_ch interface must be built with the same GRAD_WIDTH as this block.
module regularized_gradient_normalizer_core #(
  parameter int FRAC_BITS  = 16,
  parameter int GRAD_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst,
  rgn_in_if.sink     in_ch,
  rgn_out_if.source  out_ch
);

  localparam int F    = FRAC_BITS;
  localparam int G    = GRAD_WIDTH;
  localparam int QW   = 2 * G + 2;
  localparam int QX   = (QW > 2 * F + 1) ? QW : 2 * F + 1;
  localparam int QS   = QX + (QX % 2);
  localparam int RW   = QS / 2;
  localparam int QB   = rgn_pkg::DIST_W;
  localparam int DV   = rgn_pkg::LEVEL_W + F;
  localparam int SQ0  = rgn_pkg::FRONT_STAGES;
  localparam int DS0  = SQ0 + RW;
  localparam int OS   = DS0 + QB;
  localparam int NSTG = OS + 1;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;

  // Stage control: a stage loads when empty or when its successor loads.
  always_comb begin
    en[NSTG-1] = ~v[NSTG-1] | out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = ~v[k] | en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Magnitudes travel alongside until the dividers take them; signs travel on to the output stage.
  rgn_pkg::sign_t                sgn    [NSTG];
  logic [rgn_pkg::LEVEL_W-1:0]   mpsi_p [DS0];
  logic [2:0][G-1:0]             mg_p   [DS0];

  logic [2:0][G-1:0] g_in;
  assign g_in = {in_ch.grad_z, in_ch.grad_y, in_ch.grad_x};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sgn[0].level <= in_ch.level_value[rgn_pkg::LEVEL_W-1];
      mpsi_p[0]    <= in_ch.level_value[rgn_pkg::LEVEL_W-1] ?
                      -in_ch.level_value : in_ch.level_value;
      for (int i = 0; i < 3; i++) begin
        sgn[0].grad[i] <= g_in[i][G-1];
        mg_p[0][i]     <= g_in[i][G-1] ? -g_in[i] : g_in[i];
      end
    end
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_sign
    always_ff @(posedge clk) begin
      if (en[k]) begin
        sgn[k] <= sgn[k-1];
      end
    end
  end

  for (genvar k = 1; k < DS0; k++) begin : g_mag
    always_ff @(posedge clk) begin
      if (en[k]) begin
        mpsi_p[k] <= mpsi_p[k-1];
        mg_p[k]   <= mg_p[k-1];
      end
    end
  end

  // Squared magnitude and regularization.
  logic [2:0][2*G-1:0] sq1;
  logic [QX-1:0]       q2;
  logic [QX-1:0]       q3;
  logic                lo3;
  logic [F:0]          rf3;
  logic [QX-1:0]       q4;
  logic                lo4;
  logic [F:0]          rf4;
  logic [F:0]          rf2_4;
  logic [QX-1:0]       q5;
  logic                lo5;
  logic [2*F+1:0]      c5;
  logic [QS-1:0]       qr6;

  logic [2*F:0]   r_c;
  logic [2*F+1:0] rsq_c;
  assign r_c   = {1'b1, {(2*F){1'b0}}} - {q2[2*F-3:0], 2'b00};
  assign rsq_c = rf3 * rf3;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= mg_p[0][i] * mg_p[0][i];
      end
    end
    if (en[2]) begin
      q2 <= QX'(sq1[0]) + QX'(sq1[1]) + QX'(sq1[2]);
    end
    if (en[3]) begin
      q3  <= q2;
      lo3 <= (q2 >> (2 * F - 2)) == '0;
      rf3 <= r_c[2*F:F];
    end
    if (en[4]) begin
      q4    <= q3;
      lo4   <= lo3;
      rf4   <= rf3;
      rf2_4 <= rsq_c[2*F:F];
    end
    if (en[5]) begin
      q5  <= q4;
      lo5 <= lo4;
      c5  <= rf2_4 * rf4;
    end
    if (en[6]) begin
      qr6 <= lo5 ? QS'(q5 + QX'(c5 >> 2)) : QS'(q5);
    end
  end

  logic [RW-1:0] root;

  rgn_sqrt #(.QS(QS)) u_sqrt (
    .clk  (clk),
    .en   (en[SQ0 +: RW]),
    .x    (qr6),
    .root (root)
  );

  logic [RW-1:0] s_div;
  assign s_div = (root == '0) ? RW'(1) : root;

  logic [3:0][DV-1:0] num;
  logic [3:0][QB-1:0] quot;
  logic [3:0]         ovf;

  assign num[0] = {mpsi_p[DS0-1], {F{1'b0}}};
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign num[i+1] = DV'({mg_p[DS0-1][i], {F{1'b0}}});
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    rgn_div #(.DV(DV), .QB(QB), .SW(RW)) u_div (
      .clk  (clk),
      .en   (en[DS0 +: QB]),
      .num  (num[i]),
      .den  (s_div),
      .quot (quot[i]),
      .ovf  (ovf[i])
    );
  end

  function automatic logic [QB-1:0] sat_quot(logic [QB-1:0] q, logic ov, logic neg,
                                             int w);
    logic [QB:0] lim;
    logic [QB:0] mag;
    lim = ((QB+1)'(1) << w) >> 1;
    if (!neg) begin
      lim = lim - (QB+1)'(1);
    end
    mag = (ov || ({1'b0, q} > lim)) ? lim : {1'b0, q};
    return neg ? QB'(-mag) : QB'(mag);
  endfunction

  logic [QB-1:0] dx_c;
  logic [QB-1:0] dy_c;
  logic [QB-1:0] dz_c;
  assign dx_c = sat_quot(quot[1], ovf[1], sgn[OS-1].grad[0], rgn_pkg::DIR_W);
  assign dy_c = sat_quot(quot[2], ovf[2], sgn[OS-1].grad[1], rgn_pkg::DIR_W);
  assign dz_c = sat_quot(quot[3], ovf[3], sgn[OS-1].grad[2], rgn_pkg::DIR_W);

  always_ff @(posedge clk) begin
    if (en[OS]) begin
      out_ch.distance <= sat_quot(quot[0], ovf[0], sgn[OS-1].level, rgn_pkg::DIST_W);
      out_ch.dir_x    <= dx_c[rgn_pkg::DIR_W-1:0];
      out_ch.dir_y    <= dy_c[rgn_pkg::DIR_W-1:0];
      out_ch.dir_z    <= dz_c[rgn_pkg::DIR_W-1:0];
    end
  end

  assign out_ch.valid = v[OS];

  // The pipeline is empty right after reset.
  assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid after reset");

  // An accepted item lands in the first stage.
  assert property (@(posedge clk) disable iff (rst)
                   (in_ch.valid && in_ch.ready) |=> v[0])
    else $error("accepted item lost at entry");

  // The regularized magnitude never yields a zero root.
  assert property (@(posedge clk) disable iff (rst) v[DS0-1] |-> (root != '0))
    else $error("zero root reached the dividers");

  // A negative level value never gives a positive distance.
  assert property (@(posedge clk) disable iff (rst)
                   (out_ch.valid && sgn[OS].level) |->
                   (out_ch.distance[rgn_pkg::DIST_W-1] || (out_ch.distance == '0)))
    else $error("distance sign mismatch");

endmodule
